[sv/frpr_pkg.sv]
// ----------------------------------------------------------------------------
// frpr_pkg
// Types and constants of the framed packet receiver.
// ----------------------------------------------------------------------------
package frpr_pkg;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_MAIN = 3'd1,
    PH_SUB  = 3'd2,
    PH_LENH = 3'd3,
    PH_LENL = 3'd4,
    PH_DATA = 3'd5,
    PH_END  = 3'd6,
    PH_DONE = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } opcode_t;

  typedef enum logic {
    REG_START = 1'b0,
    REG_END   = 1'b1
  } cfg_reg_t;

  // buffer index width: covers length + 6 for a 16-bit length
  localparam int IDX_W = 17;

  localparam logic [IDX_W-1:0] IDX_START = 17'd0;
  localparam logic [IDX_W-1:0] IDX_MAIN  = 17'd1;
  localparam logic [IDX_W-1:0] IDX_SUB   = 17'd2;
  localparam logic [IDX_W-1:0] IDX_LENH  = 17'd3;
  localparam logic [IDX_W-1:0] IDX_LENL  = 17'd4;
  localparam logic [IDX_W-1:0] IDX_DATA  = 17'd5;
  localparam logic [IDX_W-1:0] IDX_END   = 17'd6;

  localparam logic [7:0] START_RST = 8'h02;
  localparam logic [7:0] END_RST   = 8'h03;

endpackage

[sv/framed_packet_receiver_unit.sv]
// ----------------------------------------------------------------------------
// framed_packet_receiver_unit
// Byte-wise start/length/end framed packet receiver with a frame buffer.
// ----------------------------------------------------------------------------
// Input channel (in_*): one word per item. Opcode byte feeds rx_byte to the
// frame parser, clear returns the parser to idle and drops the flags, read
// fetches one frame buffer entry (entries beyond the buffer read as zero).
// Output channel (out_*): exactly one status word per input word, in order,
// showing phase, done, end error, sticky overflow, length and read data.
// Path: an accepted word is registered in stage 1, then in the output word.
// Throughput: one word per cycle while in_stall is low; the parser updates
// its registers and the buffer RAM takes one write or one read per cycle.
// Reset: parser idle, length, count and overflow cleared, start byte 0x02,
// end byte 0x03. Buffer contents are unknown until written.
// Stall: when out_stall holds, the output word and one word in flight are
// kept; in_stall rises as soon as both are occupied.
// Config (APB): 0x0 start byte, 0x4 end byte; write only while idle.
// ----------------------------------------------------------------------------
module framed_packet_receiver_unit #(
  parameter int BUF_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_rx_byte,
  input  logic [4:0]  in_read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_phase,
  output logic        out_frame_done,
  output logic        out_end_error,
  output logic        out_overflow,
  output logic [15:0] out_payload_len,
  output logic [7:0]  out_read_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(BUF_DEPTH);
  localparam logic [frpr_pkg::IDX_W-1:0] DEPTH_IDX = frpr_pkg::IDX_W'(BUF_DEPTH);

  // configuration
  logic [7:0] start_byte_r;
  logic [7:0] end_byte_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= frpr_pkg::START_RST;
      end_byte_r   <= frpr_pkg::END_RST;
    end else if (cfg_wr) begin
      unique case (frpr_pkg::cfg_reg_t'(paddr[2]))
        frpr_pkg::REG_START: start_byte_r <= pwdata[7:0];
        frpr_pkg::REG_END:   end_byte_r   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (frpr_pkg::cfg_reg_t'(paddr[2]))
      frpr_pkg::REG_START: prdata = {24'd0, start_byte_r};
      frpr_pkg::REG_END:   prdata = {24'd0, end_byte_r};
      default:             prdata = 32'd0;
    endcase
  end

  // handshake
  logic in_acc;
  logic s1_valid_r;
  logic s1_adv;
  logic out_valid_r;

  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  // parser state
  frpr_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] count_r, count_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic        ovf_r, ovf_nxt;
  logic        err;
  logic        store;
  logic [frpr_pkg::IDX_W-1:0] wr_idx;
  logic        wr_en;
  logic        rd_en;
  logic        rd_ok;
  logic [frpr_pkg::IDX_W-1:0] rd_idx;
  logic [7:0]  ram_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= frpr_pkg::PH_IDLE;
      count_r  <= 16'd0;
      len_r    <= 16'd0;
      len_hi_r <= 8'd0;
      ovf_r    <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      len_r    <= len_nxt;
      len_hi_r <= len_hi_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    len_nxt    = len_r;
    len_hi_nxt = len_hi_r;
    ovf_nxt    = ovf_r;
    err        = 1'b0;
    store      = 1'b0;
    wr_idx     = frpr_pkg::IDX_START;
    rd_en      = 1'b0;
    if (in_acc) begin
      case (frpr_pkg::opcode_t'(in_opcode))
        frpr_pkg::OP_BYTE: begin
          unique case (phase_r)
            frpr_pkg::PH_IDLE: begin
              if (in_rx_byte == start_byte_r) begin
                store     = 1'b1;
                wr_idx    = frpr_pkg::IDX_START;
                phase_nxt = frpr_pkg::PH_MAIN;
              end
            end
            frpr_pkg::PH_MAIN: begin
              store     = 1'b1;
              wr_idx    = frpr_pkg::IDX_MAIN;
              phase_nxt = frpr_pkg::PH_SUB;
            end
            frpr_pkg::PH_SUB: begin
              store     = 1'b1;
              wr_idx    = frpr_pkg::IDX_SUB;
              phase_nxt = frpr_pkg::PH_LENH;
            end
            frpr_pkg::PH_LENH: begin
              store      = 1'b1;
              wr_idx     = frpr_pkg::IDX_LENH;
              len_hi_nxt = in_rx_byte;
              phase_nxt  = frpr_pkg::PH_LENL;
            end
            frpr_pkg::PH_LENL: begin
              store     = 1'b1;
              wr_idx    = frpr_pkg::IDX_LENL;
              len_nxt   = {len_hi_r, in_rx_byte};
              count_nxt = 16'd0;
              phase_nxt = frpr_pkg::PH_DATA;
            end
            frpr_pkg::PH_DATA: begin
              store  = 1'b1;
              wr_idx = frpr_pkg::IDX_W'(count_r) + frpr_pkg::IDX_DATA;
              if (count_r < len_r) begin
                count_nxt = count_r + 16'd1;
              end else begin
                phase_nxt = frpr_pkg::PH_END;
              end
            end
            frpr_pkg::PH_END: begin
              if (in_rx_byte == end_byte_r) begin
                store     = 1'b1;
                wr_idx    = frpr_pkg::IDX_W'(count_r) + frpr_pkg::IDX_END;
                phase_nxt = frpr_pkg::PH_DONE;
              end else begin
                err       = 1'b1;
                phase_nxt = frpr_pkg::PH_IDLE;
              end
            end
            frpr_pkg::PH_DONE: ;
            default: ;
          endcase
          if (store && (wr_idx >= DEPTH_IDX)) begin
            ovf_nxt = 1'b1;
          end
        end
        frpr_pkg::OP_CLEAR: begin
          phase_nxt = frpr_pkg::PH_IDLE;
          count_nxt = 16'd0;
          len_nxt   = 16'd0;
          ovf_nxt   = 1'b0;
        end
        frpr_pkg::OP_READ: begin
          rd_en = 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign wr_en  = store && (wr_idx < DEPTH_IDX);
  assign rd_idx = frpr_pkg::IDX_W'(in_read_index);
  assign rd_ok  = rd_en && (rd_idx < DEPTH_IDX);

  frpr_ram #(
    .WIDTH(8),
    .DEPTH(BUF_DEPTH)
  ) u_buf (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_idx[AW-1:0]),
    .wdata(in_rx_byte),
    .re   (rd_ok),
    .raddr(rd_idx[AW-1:0]),
    .rdata(ram_q)
  );

  // stage 1: status of the word whose buffer read is under way
  logic [2:0]  s1_phase_r;
  logic        s1_err_r;
  logic        s1_ovf_r;
  logic [15:0] s1_len_r;
  logic        s1_rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_phase_r <= phase_nxt;
      s1_err_r   <= err;
      s1_ovf_r   <= ovf_nxt;
      s1_len_r   <= len_nxt;
      s1_rd_r    <= rd_ok;
    end
  end

  // output word
  logic [2:0]  out_phase_r;
  logic        out_err_r;
  logic        out_ovf_r;
  logic [15:0] out_len_r;
  logic [7:0]  out_rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_phase_r <= s1_phase_r;
      out_err_r   <= s1_err_r;
      out_ovf_r   <= s1_ovf_r;
      out_len_r   <= s1_len_r;
      out_rd_r    <= s1_rd_r ? ram_q : 8'd0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_phase       = out_phase_r;
  assign out_frame_done  = (out_phase_r == frpr_pkg::PH_DONE);
  assign out_end_error   = out_err_r;
  assign out_overflow    = out_ovf_r;
  assign out_payload_len = out_len_r;
  assign out_read_data   = out_rd_r;

  // checks
  a_err_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_end_error) |-> (out_phase == frpr_pkg::PH_IDLE))
    else $error("end error without return to idle");

  a_ram_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_rd_r && !s1_adv) |=> $stable(ram_q))
    else $error("buffer read data lost while stage 1 held");

  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (wr_idx < DEPTH_IDX) && !rd_en)
    else $error("buffer write out of range or with a read");

  a_ovf_set: assert property (@(posedge clk) disable iff (!rst_n)
    (store && (wr_idx >= DEPTH_IDX)) |=> ovf_r)
    else $error("dropped store did not set overflow");

  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_phase) && $stable(out_read_data)))
    else $error("stalled output word changed");

endmodule

[sv/frpr_ram.sv]
// ----------------------------------------------------------------------------
// frpr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module frpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[tb/tb_framed_packet_receiver_unit.sv]
// ----------------------------------------------------------------------------
// tb_framed_packet_receiver_unit
// Self-checking testbench for the framed packet receiver.
// ----------------------------------------------------------------------------
// Drives byte, clear, read and spare words into the input channel with random
// gaps and output stalls. An in-house frame parser model predicts the status
// word for every accepted word, and each output word is checked field by
// field in order. Directed frames come first, then random framed traffic
// under several start/end byte settings, including the extremes.
// ----------------------------------------------------------------------------
module tb_framed_packet_receiver_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    frpr_pkg::phase_t phase;
    logic        done;
    logic        err;
    logic        ovf;
    logic [15:0] len;
    logic [7:0]  rd;
  } status_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_opcode;
  logic [7:0]  in_rx_byte;
  logic [4:0]  in_read_index;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_phase;
  logic        out_frame_done;
  logic        out_end_error;
  logic        out_overflow;
  logic [15:0] out_payload_len;
  logic [7:0]  out_read_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // parser model state
  frpr_pkg::phase_t rx_ph;
  logic [7:0]       frame_mem [DEPTH];
  bit [DEPTH-1:0]   loaded_mask;
  logic [15:0]      data_cnt;
  logic [15:0]      len_field;
  logic             ovf_flag;
  logic [7:0]       start_val;
  logic [7:0]       end_val;

  status_t status_q [$];

  int  errors = 0;
  int  useful_words;
  int  frames_done;
  int  bad_ends;
  int  reads_done;
  int  ovf_hits;
  int  cycle_cnt = 0;
  bit  jitter_on;

  framed_packet_receiver_unit #(.BUF_DEPTH(DEPTH)) i_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= jitter_on && ($urandom_range(99) < 32);
    end
  end

  function automatic void mismatch(input string field, input logic [15:0] want,
                                   input logic [15:0] got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    errors++;
  endfunction

  always @(posedge clk) begin
    status_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (status_q.size() == 0) begin
        $display("%0t: status word with nothing expected", $time);
        errors++;
      end else begin
        want = status_q.pop_front();
        if (out_phase !== want.phase) mismatch("phase", want.phase, out_phase);
        if (out_frame_done !== want.done) mismatch("frame_done", want.done, out_frame_done);
        if (out_end_error !== want.err) mismatch("end_error", want.err, out_end_error);
        if (out_overflow !== want.ovf) mismatch("overflow", want.ovf, out_overflow);
        if (out_payload_len !== want.len) mismatch("payload_len", want.len, out_payload_len);
        if (out_read_data !== want.rd) mismatch("read_data", want.rd, out_read_data);
      end
    end
  end

  function automatic void keep_byte(input int idx, input logic [7:0] v);
    if (idx < DEPTH) begin
      frame_mem[idx] = v;
      loaded_mask[idx] = 1'b1;
    end else begin
      if (!ovf_flag) ovf_hits++;
      ovf_flag = 1'b1;
    end
  endfunction

  // returns 0 for a spare word and for a byte that leaves the parser untouched
  function automatic bit predict_status(input logic [1:0] op, input logic [7:0] b,
                                        input logic [4:0] ridx);
    status_t s;
    bit busy;
    s = '0;
    busy = 1'b1;
    case (op)
      frpr_pkg::OP_BYTE: begin
        case (rx_ph)
          frpr_pkg::PH_IDLE: begin
            if (b == start_val) begin
              keep_byte(0, b);
              rx_ph = frpr_pkg::PH_MAIN;
            end else begin
              busy = 1'b0;
            end
          end
          frpr_pkg::PH_MAIN: begin
            keep_byte(1, b);
            rx_ph = frpr_pkg::PH_SUB;
          end
          frpr_pkg::PH_SUB: begin
            keep_byte(2, b);
            rx_ph = frpr_pkg::PH_LENH;
          end
          frpr_pkg::PH_LENH: begin
            keep_byte(3, b);
            rx_ph = frpr_pkg::PH_LENL;
          end
          frpr_pkg::PH_LENL: begin
            keep_byte(4, b);
            len_field = {frame_mem[3], b};
            data_cnt = '0;
            rx_ph = frpr_pkg::PH_DATA;
          end
          frpr_pkg::PH_DATA: begin
            keep_byte(int'(data_cnt) + 5, b);
            if (data_cnt < len_field) data_cnt = data_cnt + 16'd1;
            else rx_ph = frpr_pkg::PH_END;
          end
          frpr_pkg::PH_END: begin
            if (b == end_val) begin
              keep_byte(int'(data_cnt) + 6, b);
              rx_ph = frpr_pkg::PH_DONE;
              frames_done++;
            end else begin
              rx_ph = frpr_pkg::PH_IDLE;
              s.err = 1'b1;
              bad_ends++;
            end
          end
          default: busy = 1'b0;
        endcase
      end
      frpr_pkg::OP_CLEAR: begin
        rx_ph = frpr_pkg::PH_IDLE;
        data_cnt = '0;
        len_field = '0;
        ovf_flag = 1'b0;
      end
      frpr_pkg::OP_READ: begin
        s.rd = frame_mem[ridx];
        reads_done++;
      end
      default: busy = 1'b0;
    endcase
    s.phase = rx_ph;
    s.done = (rx_ph == frpr_pkg::PH_DONE);
    s.ovf = ovf_flag;
    s.len = len_field;
    status_q.push_back(s);
    return busy;
  endfunction

  task automatic send_word(input logic [1:0] op, input logic [7:0] b, input logic [4:0] ridx);
    @(negedge clk);
    while (jitter_on && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_rx_byte <= b;
    in_read_index <= ridx;
    do @(posedge clk); while (in_stall);
    if (predict_status(op, b, ridx)) useful_words++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(frpr_pkg::OP_BYTE, b, 5'($urandom_range(31)));
  endtask

  task automatic send_clear();
    send_word(frpr_pkg::OP_CLEAR, 8'($urandom_range(255)), 5'($urandom_range(31)));
  endtask

  task automatic send_spare();
    send_word(OP_SPARE, 8'($urandom_range(255)), 5'($urandom_range(31)));
  endtask

  task automatic read_entry(input logic [4:0] idx);
    send_word(frpr_pkg::OP_READ, 8'($urandom_range(255)), idx);
  endtask

  // cut >= 0 aborts with a clear before that payload byte
  task automatic send_frame(input logic [15:0] plen, input bit bad_end, input int cut);
    int i;
    if (rx_ph != frpr_pkg::PH_IDLE) send_clear();
    send_byte(start_val);
    send_byte(8'($urandom_range(255)));
    send_byte(8'($urandom_range(255)));
    send_byte(plen[15:8]);
    send_byte(plen[7:0]);
    for (i = 0; i <= plen; i++) begin
      if (i == cut) begin
        send_clear();
        return;
      end
      send_byte(8'($urandom_range(255)));
    end
    if (bad_end) send_byte(end_val ^ 8'($urandom_range(1, 255)));
    else send_byte(end_val);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
  endtask

  task automatic program_reg(input frpr_pkg::cfg_reg_t r, input logic [7:0] v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= {24'h0, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (r == frpr_pkg::REG_START) start_val = v;
    else end_val = v;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== v) begin
      $display("%0t: register %s readback, expected %0h, actual %0h",
               $time, r.name(), v, prdata[7:0]);
      errors++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [4:0] pick_loaded();
    logic [4:0] k;
    k = 5'($urandom_range(31));
    while (!loaded_mask[k]) k = k + 5'd1;
    return k;
  endfunction

  function automatic logic [15:0] pick_payload_len();
    if ($urandom_range(99) < 5) return 16'($urandom_range(41, 300));
    return 16'($urandom_range(0, 40));
  endfunction

  task automatic test_basic_frame();
    send_byte(start_val);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(end_val);
    send_byte(start_val);  // ignored while done
    send_spare();
    read_entry(5'd0);
    read_entry(5'd7);
  endtask

  task automatic test_wrong_end_byte();
    send_frame(16'd0, 1'b1, -1);
  endtask

  task automatic test_long_length_abort();
    send_frame(16'hFFFF, 1'b0, 3);
  endtask

  task automatic test_random_traffic(input logic [7:0] sb, input logic [7:0] eb,
                                     input bit quiet, input int budget);
    int goal;
    int k;
    logic [15:0] plen;
    settle();
    program_reg(frpr_pkg::REG_START, sb);
    program_reg(frpr_pkg::REG_END, eb);
    jitter_on = !quiet;
    goal = useful_words + budget;
    while (useful_words < goal) begin
      k = $urandom_range(99);
      if (k < 55) begin
        send_frame(pick_payload_len(), 1'b0, -1);
      end else if (k < 65) begin
        plen = pick_payload_len();
        if ($urandom_range(1)) send_frame(plen, 1'b1, -1);
        else send_frame(plen, 1'b0, $urandom_range(0, int'(plen)));
      end else if (k < 78) begin
        if (loaded_mask != 0) repeat ($urandom_range(1, 3)) read_entry(pick_loaded());
      end else if (k < 86) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
      end else if (k < 92) begin
        send_clear();
      end else if (k < 96) begin
        send_spare();
      end else begin
        send_frame({8'($urandom_range(1, 255)), 8'($urandom_range(255))}, 1'b0,
                   $urandom_range(0, 5));
      end
    end
    jitter_on = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = frpr_pkg::OP_BYTE;
    in_rx_byte = '0;
    in_read_index = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rx_ph = frpr_pkg::PH_IDLE;
    loaded_mask = '0;
    data_cnt = '0;
    len_field = '0;
    ovf_flag = 1'b0;
    start_val = frpr_pkg::START_RST;
    end_val = frpr_pkg::END_RST;
    useful_words = 0;
    frames_done = 0;
    bad_ends = 0;
    reads_done = 0;
    ovf_hits = 0;
    jitter_on = 1'b1;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_basic_frame();
    test_wrong_end_byte();
    test_long_length_abort();
    test_random_traffic(frpr_pkg::START_RST, frpr_pkg::END_RST, 1'b0, 300);
    test_random_traffic(8'h00, 8'hFF, 1'b0, 300);
    test_random_traffic(8'hFF, 8'h00, 1'b1, 300);
    test_random_traffic(8'hA5, 8'hA5, 1'b0, 300);
    test_random_traffic(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0, 300);

    settle();
    repeat (8) @(posedge clk);
    $display("Covered %0d parser words, %0d complete frames, %0d bad end bytes,",
             useful_words, frames_done, bad_ends);
    $display("%0d buffer reads and %0d overflow events over five start/end settings",
             reads_done, ovf_hits);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
